// ===== src/sqrtnb_pkg.sv =====
// Shared constants for the fixed-point square root block.
package sqrtnb_pkg;

   localparam int VAL_W      = 32;  // radicand and root width
   localparam int TOL_W      = 16;  // tolerance register width
   localparam int ITER_OUT_W = 7;   // iterations field width
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_NEWTON = 8'd1;

   localparam logic [TOL_W-1:0] TOL_RESET        = 16'd66;
   localparam logic             USE_NEWTON_RESET = 1'b1;

endpackage

// ===== src/square_root_newton_or_bisection.sv =====
// Fixed-point square root: Newton-Raphson with a serial divider, or bisection.
// Sequencing: Newton squares the estimate, then runs the serial divider (one radix-2
//   divider bit per cycle) for each step; bisection first tests the upper endpoint
//   (an exact upper endpoint answers without bisection steps), then squares and halves;
//   a zero radicand in bisection answers in the cycle after start.
// Throughput: one item at a time; busy stays high until the result strobe.
// A shared 32x32 multiplier squares the estimate once per step.
// Reset (synchronous) returns to idle and restores tolerance = 66, use_newton = 1.
module square_root_newton_or_bisection #(
   parameter int MAX_ITER  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [sqrtnb_pkg::VAL_W-1:0]             req_radicand,
   output logic                                     rsp_valid,
   output logic [sqrtnb_pkg::VAL_W-1:0]             rsp_root,
   output logic [sqrtnb_pkg::ITER_OUT_W-1:0]        rsp_iterations,
   output logic                                     rsp_not_converged,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [sqrtnb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sqrtnb_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int XW     = sqrtnb_pkg::VAL_W;
   localparam int SW     = 2 * XW;             // square width
   localparam int QW     = XW + FRAC_BITS;     // scaled radicand / quotient width
   localparam int ITER_W = $clog2(MAX_ITER + 1);
   localparam int DCNT_W = $clog2(QW);
   localparam int TW     = sqrtnb_pkg::TOL_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_MID,
      ST_DIV,
      ST_NSTEP
   } state_type;

   state_type             state_ff, state_in;
   logic [XW-1:0]         v_ff, v_in;
   logic [XW-1:0]         x_ff, x_in;
   logic [XW-1:0]         a_ff, a_in;
   logic [XW-1:0]         b_ff, b_in;
   logic [SW-1:0]         s_ff, s_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [QW-1:0]         dq_ff, dq_in;
   logic [XW:0]           rem_ff, rem_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic                  down_ff, down_in;
   logic                  endp_ff, endp_in;
   logic                  newton_ff, newton_in;
   logic [TW-1:0]         tol_ff, tol_in;
   logic                  use_newton_ff, use_newton_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]         rsp_root_ff, rsp_root_in;
   logic [sqrtnb_pkg::ITER_OUT_W-1:0] rsp_iter_ff, rsp_iter_in;
   logic                  rsp_nc_ff, rsp_nc_in;

   logic [SW-1:0]         big_v;
   logic [SW-1:0]         big_e;
   logic                  s_ge_v;
   logic [SW-1:0]         err;
   logic [XW-1:0]         start_hi;
   logic [XW+1:0]         trial;
   logic [XW+1:0]         dsr;
   logic                  trial_ge;
   logic [QW:0]           up_sum;
   logic                  fin;
   logic                  fin_fail;

   assign big_v    = SW'({v_ff, {FRAC_BITS{1'b0}}});
   assign big_e    = SW'({tol_ff, {FRAC_BITS{1'b0}}});
   assign s_ge_v   = (s_ff >= big_v);
   assign err      = s_ge_v ? (s_ff - big_v) : (big_v - s_ff);
   // max(radicand, 1.0)
   assign start_hi = (req_radicand[XW-1:FRAC_BITS] == '0) ? XW'(1 << FRAC_BITS) : req_radicand;
   assign trial    = {rem_ff, dq_ff[QW-1]};
   assign dsr      = {1'b0, x_ff, 1'b0};
   assign trial_ge = (trial >= dsr);
   assign up_sum   = (QW + 1)'(dq_ff) + (QW + 1)'(x_ff);

   always_comb begin
      state_in      = state_ff;
      v_in          = v_ff;
      x_in          = x_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      s_in          = s_ff;
      iter_in       = iter_ff;
      dq_in         = dq_ff;
      rem_in        = rem_ff;
      dcnt_in       = dcnt_ff;
      down_in       = down_ff;
      endp_in       = endp_ff;
      newton_in     = newton_ff;
      tol_in        = tol_ff;
      use_newton_in = use_newton_ff;
      rsp_valid_in  = 1'b0;
      rsp_root_in   = rsp_root_ff;
      rsp_iter_in   = rsp_iter_ff;
      rsp_nc_in     = rsp_nc_ff;
      fin           = 1'b0;
      fin_fail      = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            sqrtnb_pkg::CSR_TOLERANCE:  tol_in        = csr_wdata[TW-1:0];
            sqrtnb_pkg::CSR_USE_NEWTON: use_newton_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               v_in      = req_radicand;
               iter_in   = '0;
               a_in      = '0;
               b_in      = start_hi;
               x_in      = start_hi;
               newton_in = use_newton_ff;
               endp_in   = !use_newton_ff;
               if (!use_newton_ff && req_radicand == '0) begin
                  // lower endpoint is exact
                  rsp_valid_in = 1'b1;
                  rsp_root_in  = '0;
                  rsp_iter_in  = '0;
                  rsp_nc_in    = 1'b0;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            s_in     = x_ff * x_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (endp_ff) begin
               if (s_ff == big_v) begin
                  fin = 1'b1;
               end else begin
                  x_in     = v_ff;
                  endp_in  = 1'b0;
                  state_in = ST_MUL;
               end
            end else begin
               // bisection: shrink the interval around the last midpoint
               if (!newton_ff && iter_ff != '0) begin
                  if (!s_ge_v) a_in = x_ff;
                  else         b_in = x_ff;
               end
               if (err <= big_e) begin
                  fin = 1'b1;
               end else if (iter_ff >= ITER_W'(MAX_ITER)) begin
                  fin      = 1'b1;
                  fin_fail = 1'b1;
               end else if (newton_ff) begin
                  if (x_ff == '0) begin
                     fin      = 1'b1;
                     fin_fail = 1'b1;
                  end else begin
                     // quotient fits QW bits, so the top bits start as remainder
                     down_in  = s_ge_v;
                     rem_in   = (XW + 1)'(err >> QW);
                     dq_in    = err[QW-1:0];
                     dcnt_in  = '0;
                     state_in = ST_DIV;
                  end
               end else begin
                  state_in = ST_MID;
               end
            end
         end
         ST_MID: begin
            x_in     = XW'(((XW + 1)'(a_ff) + (XW + 1)'(b_ff)) >> 1);
            iter_in  = iter_ff + 1'b1;
            state_in = ST_MUL;
         end
         ST_DIV: begin
            rem_in  = trial_ge ? (XW + 1)'(trial - dsr) : trial[XW:0];
            dq_in   = {dq_ff[QW-2:0], trial_ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(QW - 1)) state_in = ST_NSTEP;
         end
         ST_NSTEP: begin
            if (down_ff) begin
               x_in = x_ff - dq_ff[XW-1:0];
            end else if (up_sum[QW:XW] != '0) begin
               x_in = '1;
            end else begin
               x_in = up_sum[XW-1:0];
            end
            iter_in  = iter_ff + 1'b1;
            state_in = ST_MUL;
         end
         default: state_in = ST_IDLE;
      endcase

      if (fin) begin
         rsp_valid_in = 1'b1;
         rsp_root_in  = x_ff;
         rsp_iter_in  = sqrtnb_pkg::ITER_OUT_W'(iter_ff);
         rsp_nc_in    = fin_fail;
         state_in     = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      x_ff        <= x_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      s_ff        <= s_in;
      iter_ff     <= iter_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      dcnt_ff     <= dcnt_in;
      down_ff     <= down_in;
      endp_ff     <= endp_in;
      newton_ff   <= newton_in;
      rsp_root_ff <= rsp_root_in;
      rsp_iter_ff <= rsp_iter_in;
      rsp_nc_ff   <= rsp_nc_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         tol_ff        <= sqrtnb_pkg::TOL_RESET;
         use_newton_ff <= sqrtnb_pkg::USE_NEWTON_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tol_ff        <= tol_in;
         use_newton_ff <= use_newton_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_root          = rsp_root_ff;
   assign rsp_iterations    = rsp_iter_ff;
   assign rsp_not_converged = rsp_nc_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !(!use_newton_ff && req_radicand == '0)) |=> busy)
      else $error("accepted item did not start the sequencer");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while sequencer busy");

   a_fail_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_not_converged) |->
         (rsp_iterations == sqrtnb_pkg::ITER_OUT_W'(MAX_ITER) || rsp_root == '0))
      else $error("not_converged without cap or zero estimate");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dcnt_ff <= DCNT_W'(QW - 1)))
      else $error("divider step counter out of range");

   a_bisect_order: assert property (@(posedge clock) disable iff (reset)
      (busy && !newton_ff) |-> (a_ff <= b_ff))
      else $error("bisection interval inverted");

endmodule

// ===== verif/square_root_newton_or_bisection_tb.sv =====
// Testbench for the fixed-point square root block: random and directed items vs a predictor.
module square_root_newton_or_bisection_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_STEPS        = 64;
   localparam int FRAC             = 16;
   localparam int NUM_PHASES       = 10;
   localparam int RANDOM_PER_PHASE = 163;
   localparam int DRAIN_CYCLES     = 3500;
   // 1650 items at the worst Newton latency (64 steps of a serial divide) plus gaps, x4
   localparam longint LIMIT_CYCLES = 25_000_000;
   localparam logic [63:0] ONE     = 64'd1 << FRAC;

   typedef struct packed {
      logic [sqrtnb_pkg::VAL_W-1:0]      root;
      logic [sqrtnb_pkg::ITER_OUT_W-1:0] iterations;
      logic                              not_converged;
   } sqrt_result_type;

   typedef struct packed {
      logic [sqrtnb_pkg::VAL_W-1:0] radicand;
      sqrt_result_type              want;
   } root_check_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic                              busy;
   logic [sqrtnb_pkg::VAL_W-1:0]      req_radicand = '0;
   logic                              rsp_valid;
   logic [sqrtnb_pkg::VAL_W-1:0]      rsp_root;
   logic [sqrtnb_pkg::ITER_OUT_W-1:0] rsp_iterations;
   logic                              rsp_not_converged;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [sqrtnb_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [sqrtnb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   square_root_newton_or_bisection #(
      .MAX_ITER (MAX_STEPS),
      .FRAC_BITS(FRAC)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_radicand     (req_radicand),
      .rsp_valid        (rsp_valid),
      .rsp_root         (rsp_root),
      .rsp_iterations   (rsp_iterations),
      .rsp_not_converged(rsp_not_converged),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // register copies used by the predictor
   logic [sqrtnb_pkg::TOL_W-1:0] tol_cfg    = sqrtnb_pkg::TOL_RESET;
   logic                         newton_cfg = sqrtnb_pkg::USE_NEWTON_RESET;

   logic [sqrtnb_pkg::VAL_W-1:0] radicand_backlog [$];
   root_check_type               expected_roots [$];

   int     items_queued     = 0;
   int     items_accepted   = 0;
   int     newton_items     = 0;
   int     bisect_items     = 0;
   int     unconverged_seen = 0;
   int     settings_used    = 1;
   int     mismatches       = 0;
   longint cycle_count      = 0;

   int tol_plan    [NUM_PHASES] = '{66, 65535, 1, 0, -1, 65535, 1, 0, -1, -1};
   int newton_plan [NUM_PHASES] = '{1, 1, 0, 1, 0, 0, 1, 0, 1, 0};

   function automatic logic [63:0] square_error(input logic [63:0] est,
                                                input logic [63:0] target);
      logic [63:0] sq;
      sq = est * est;
      return (sq >= target) ? sq - target : target - sq;
   endfunction

   function automatic sqrt_result_type predict_root(
         input logic [sqrtnb_pkg::VAL_W-1:0] radicand,
         input logic [sqrtnb_pkg::TOL_W-1:0] tol,
         input logic newton);
      logic [63:0]     target;
      logic [63:0]     limit;
      logic [63:0]     est;
      logic [63:0]     lo;
      logic [63:0]     hi;
      logic [63:0]     sq;
      logic [63:0]     step;
      int unsigned     steps;
      logic            stuck;
      sqrt_result_type res;
      target = {32'd0, radicand} << FRAC;
      limit  = {48'd0, tol} << FRAC;
      steps  = 0;
      stuck  = 1'b0;
      if (newton) begin
         est = ({32'd0, radicand} < ONE) ? ONE : {32'd0, radicand};
         while (square_error(est, target) > limit) begin
            if (steps >= MAX_STEPS || est == 64'd0) begin
               stuck = 1'b1;
               break;
            end
            sq = est * est;
            if (sq >= target) begin
               step = (sq - target) / (est << 1);
               est  = est - step;
            end else begin
               step = (target - sq) / (est << 1);
               est  = (est + step > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : est + step;
            end
            steps++;
         end
      end else begin
         lo = 64'd0;
         hi = ({32'd0, radicand} < ONE) ? ONE : {32'd0, radicand};
         if (target == 64'd0) begin
            est = 64'd0;     // lower endpoint is exact
         end else if (hi * hi == target) begin
            est = hi;        // upper endpoint is exact
         end else begin
            est = {32'd0, radicand};
            while (square_error(est, target) > limit) begin
               if (steps >= MAX_STEPS) begin
                  stuck = 1'b1;
                  break;
               end
               est = (lo + hi) >> 1;
               if (est * est < target) lo = est;
               else hi = est;
               steps++;
            end
         end
      end
      res.root          = est[sqrtnb_pkg::VAL_W-1:0];
      res.iterations    = steps[sqrtnb_pkg::ITER_OUT_W-1:0];
      res.not_converged = stuck;
      return res;
   endfunction

   // ---------------- monitor: checks results, predicts accepted items ----------------
   logic            took = 1'b0;
   root_check_type  pending_check;
   sqrt_result_type got;

   always @(posedge clock) begin
      if (reset) begin
         took <= 1'b0;
      end else begin
         if (rsp_valid) begin
            got = '{root: rsp_root, iterations: rsp_iterations,
                    not_converged: rsp_not_converged};
            if (expected_roots.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result with no item outstanding: root=%h iter=%0d nc=%b",
                           got.root, got.iterations, got.not_converged);
            end else begin
               pending_check = expected_roots.pop_front();
               if (got.root !== pending_check.want.root ||
                   got.iterations !== pending_check.want.iterations ||
                   got.not_converged !== pending_check.want.not_converged) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch radicand=%h tol=%0d newton=%b: expected root=%h",
                               " iter=%0d nc=%b, got root=%h iter=%0d nc=%b"},
                              pending_check.radicand, tol_cfg, newton_cfg,
                              pending_check.want.root, pending_check.want.iterations,
                              pending_check.want.not_converged,
                              got.root, got.iterations, got.not_converged);
               end
            end
         end
         took <= start && !busy;
         if (start && !busy) begin
            pending_check.radicand = req_radicand;
            pending_check.want     = predict_root(req_radicand, tol_cfg, newton_cfg);
            expected_roots.push_back(pending_check);
            items_accepted++;
            if (newton_cfg) newton_items++;
            else bisect_items++;
            if (pending_check.want.not_converged) unconverged_seen++;
         end
      end
   end

   // ---------------- driver: feeds the backlog with random gaps ----------------
   logic                         next_start = 1'b0;
   logic [sqrtnb_pkg::VAL_W-1:0] next_radicand;
   int                           gap_left = 0;
   logic                         gap_any  = 1'b0;
   logic                         burst    = 1'b0;

   always @(negedge clock) begin
      if (!reset) begin
         next_start = start;
         if (start && took) begin
            // item taken at the last rising edge
            next_start = 1'b0;
            if ($urandom_range(0, 29) == 0) burst = ~burst;
            gap_left = burst ? 0 : $urandom_range(0, 17);
            gap_any  = $urandom_range(0, 1);
         end
         if (!next_start && radicand_backlog.size() > 0) begin
            if (gap_left == 0) begin
               next_start    = 1'b1;
               next_radicand = radicand_backlog.pop_front();
               req_radicand <= next_radicand;
            end else if (!busy || gap_any) begin
               gap_left--;
            end
         end
         start <= next_start;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d items still expected",
                  cycle_count, expected_roots.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------- sequencing ----------------
   task automatic write_csr(input logic [sqrtnb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sqrtnb_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == sqrtnb_pkg::CSR_TOLERANCE) tol_cfg = data[sqrtnb_pkg::TOL_W-1:0];
      else if (idx == sqrtnb_pkg::CSR_USE_NEWTON) newton_cfg = data[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_radicand(input logic [sqrtnb_pkg::VAL_W-1:0] value);
      radicand_backlog.push_back(value);
      items_queued++;
   endtask

   task automatic wait_drained();
      while (items_accepted != items_queued || expected_roots.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [sqrtnb_pkg::VAL_W-1:0] pick_radicand();
      logic [sqrtnb_pkg::VAL_W-1:0] n;
      n = $urandom_range(0, 16'hFFFF);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 16'hFFFF);          // below one
         2: return n * n;                                // exact square
         3: return n * n + $urandom_range(0, 2) - 1;     // next to a square
         4: return $urandom_range(0, 32'h00FF_FFFF);
         default: return {1'b1, 31'($urandom)};
      endcase
   endfunction

   initial begin
      logic [sqrtnb_pkg::VAL_W-1:0]      newton_edges [14];
      logic [sqrtnb_pkg::VAL_W-1:0]      bisect_edges [6];
      logic [sqrtnb_pkg::TOL_W-1:0]      tol_value;
      logic [sqrtnb_pkg::CSR_DATA_W-1:0] junk;

      newton_edges = '{32'h0000_0000, 32'h0000_0001, 32'h0000_8000, 32'h0000_FFFF,
                       32'h0001_0000, 32'h0001_0001, 32'h0004_0000, 32'h0009_0000,
                       32'h0002_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'hAAAA_AAAA, 32'h5555_5555};
      bisect_edges = '{32'h0000_0000, 32'h0001_0000, 32'h0004_0000, 32'hFFFF_FFFF,
                       32'h0000_0001, 32'h0002_0000};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: Newton, tolerance 66
      foreach (newton_edges[i]) queue_radicand(newton_edges[i]);
      wait_drained();

      // bisection, including both exact endpoints
      write_csr(sqrtnb_pkg::CSR_USE_NEWTON, '0);
      settings_used++;
      foreach (bisect_edges[i]) queue_radicand(bisect_edges[i]);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         tol_value = (tol_plan[p] < 0) ? sqrtnb_pkg::TOL_W'($urandom_range(1, 65535))
                                       : sqrtnb_pkg::TOL_W'(tol_plan[p]);
         // odd settings carry junk above the register width
         junk = (p % 2) ? $urandom : '0;
         write_csr(sqrtnb_pkg::CSR_TOLERANCE,
                   {junk[sqrtnb_pkg::CSR_DATA_W-1:sqrtnb_pkg::TOL_W], tol_value});
         write_csr(sqrtnb_pkg::CSR_USE_NEWTON,
                   {junk[sqrtnb_pkg::CSR_DATA_W-1:1], 1'(newton_plan[p])});
         settings_used++;
         for (int k = 0; k < RANDOM_PER_PHASE; k++) queue_radicand(pick_radicand());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb summary: %0d items checked (%0d Newton, %0d bisection) over %0d settings",
               items_accepted, newton_items, bisect_items, settings_used);
      $display("tb summary: %0d results expected not converged, %0d mismatches",
               unconverged_seen, mismatches);
      if (mismatches == 0 && expected_roots.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
